>>> sv/ugc_pkg.sv
package ugc_pkg;
  localparam int MaxPointsDef = 1024;
  localparam int CoordBitsDef = 16;
  localparam int MaxBinsDef   = 64;
  localparam int CfgW         = 7;
  localparam int IdxW         = 10;
  localparam int CellW        = 6;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] REG_BINS_X = 2'd0;
  localparam logic [1:0] REG_BINS_Y = 2'd1;
  localparam logic [1:0] REG_BINS_Z = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // store point, widen bounds
    logic clear;     // empty set
    logic capture;   // latch query index
    logic rd;        // issue store read
    logic div_start; // start cell divisions
    logic out_load;  // put result in output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;       // query index at or past count
    logic div_done;
  } sts_t;
endpackage

>>> sv/ugc_ctrl.sv
module ugc_ctrl
  import ugc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  output logic       out_valid,
  input  logic       out_ready,
  input  sts_t       sts,
  output ctl_t       ctl
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_DIV  = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   acc;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (op_t'(in_opcode))
            OP_LOAD:  ctl.load = 1'b1;
            OP_CLEAR: ctl.clear = 1'b1;
            OP_QUERY: begin
              ctl.capture = 1'b1;
              ctl.rd = 1'b1;
              state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (sts.bad) begin
          state_nxt = S_OUT;
        end else begin
          ctl.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: if (sts.div_done) state_nxt = S_OUT;
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ctl.out_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

>>> sv/ugc_div.sv
// Restoring divider, one quotient bit a cycle, three axes in lockstep.
module ugc_div
  import ugc_pkg::*;
#(
  parameter int CoordBits = CoordBitsDef,
  parameter int BinW      = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [CoordBits-1:0]   off   [3],
  input  logic [CoordBits-1:0]   range [3],
  input  logic [BinW-1:0]        nbins [3],
  output logic                   done,
  output logic [BinW-1:0]        quo   [3]
);
  localparam int NumW  = CoordBits + BinW;
  localparam int Steps = BinW;
  localparam int StepW = $clog2(Steps + 1);

  logic [NumW-1:0]      num_r [3];
  logic [NumW-1:0]      num_nxt [3];
  logic [CoordBits:0]   rem_r [3];
  logic [CoordBits:0]   rem_nxt [3];
  logic [BinW-1:0]      q_r [3];
  logic [BinW-1:0]      q_nxt [3];
  logic                 busy_r;
  logic [StepW-1:0]     step_r;
  logic [CoordBits+1:0] trial [3];
  logic [NumW-1:0]      prod [3];

  // off*bins < range*2^BinW, so quotient fits in BinW bits
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a]    = NumW'(off[a]) * NumW'(nbins[a]);
      trial[a]   = {rem_r[a], num_r[a][NumW-1]} - {2'b0, range[a]};
      num_nxt[a] = num_r[a];
      rem_nxt[a] = rem_r[a];
      q_nxt[a]   = q_r[a];
      if (start) begin
        // upper part of the product is already below range; only the low
        // BinW bits need a step each
        num_nxt[a] = prod[a] << CoordBits;
        rem_nxt[a] = {1'b0, prod[a][NumW-1:BinW]};
        q_nxt[a]   = '0;
      end else if (busy_r) begin
        num_nxt[a] = num_r[a] << 1;
        if (!trial[a][CoordBits+1]) begin
          rem_nxt[a] = trial[a][CoordBits:0];
          q_nxt[a]   = {q_r[a][BinW-2:0], 1'b1};
        end else begin
          rem_nxt[a] = {rem_r[a][CoordBits-1:0], num_r[a][NumW-1]};
          q_nxt[a]   = {q_r[a][BinW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == StepW'(Steps - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      num_r[a] <= num_nxt[a];
      rem_r[a] <= rem_nxt[a];
      q_r[a]   <= q_nxt[a];
    end
  end

  assign done = busy_r && (step_r == StepW'(Steps - 1));
  assign quo  = q_r;
endmodule

>>> sv/ugc_dp.sv
module ugc_dp
  import ugc_pkg::*;
#(
  parameter int MaxPoints = MaxPointsDef,
  parameter int CoordBits = CoordBitsDef,
  parameter int MaxBins   = MaxBinsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CfgW-1:0]       cfg_data,
  input  logic [CoordBits-1:0]  in_x,
  input  logic [CoordBits-1:0]  in_y,
  input  logic [CoordBits-1:0]  in_z,
  input  logic [IdxW-1:0]       in_qi,
  output logic [IdxW-1:0]       out_pi,
  output logic [CellW-1:0]      out_cx,
  output logic [CellW-1:0]      out_cy,
  output logic [CellW-1:0]      out_cz,
  output logic                  out_bad
);
  localparam int AW   = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int BinW = $clog2(MaxBins + 1);
  localparam int SW   = 3 * CoordBits;
  localparam int CmpW = ((IdxW > CntW) ? IdxW : CntW) + 1;

  logic [SW-1:0]          mem [MaxPoints];
  logic [SW-1:0]          rd_r;
  logic [CntW-1:0]        cnt_r;
  logic signed [CoordBits-1:0] mn_r [3];
  logic signed [CoordBits-1:0] mx_r [3];
  logic [CfgW-1:0]        bins_r [3];
  logic [IdxW-1:0]        qi_r;
  logic                   bad_r;
  logic signed [CoordBits-1:0] c [3];
  logic [CoordBits-1:0]   off [3];
  logic [CoordBits-1:0]   rng [3];
  logic [BinW-1:0]        eb [3];
  logic [BinW-1:0]        q [3];
  logic [BinW-1:0]        cl [3];
  logic                   full;
  logic                   div_done;

  assign c[0] = in_x;
  assign c[1] = in_y;
  assign c[2] = in_z;
  assign full = (cnt_r == CntW'(MaxPoints));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) bins_r[a] <= CfgW'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BINS_X: bins_r[0] <= cfg_data;
        REG_BINS_Y: bins_r[1] <= cfg_data;
        REG_BINS_Z: bins_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.clear) begin
      cnt_r <= '0;
    end else if (ctl.load && !full) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && !full) begin
      mem[cnt_r[AW-1:0]] <= {c[2], c[1], c[0]};
      for (int a = 0; a < 3; a++) begin
        if (cnt_r == '0 || c[a] < mn_r[a]) mn_r[a] <= c[a];
        if (cnt_r == '0 || c[a] > mx_r[a]) mx_r[a] <= c[a];
      end
    end
    if (ctl.rd) rd_r <= mem[AW'(in_qi)];
    if (ctl.capture) begin
      qi_r  <= in_qi;
      bad_r <= CmpW'(in_qi) >= CmpW'(cnt_r);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      off[a] = rd_r[a*CoordBits +: CoordBits] - mn_r[a];
      rng[a] = mx_r[a] - mn_r[a];
      if (bins_r[a] == '0)                   eb[a] = BinW'(1);
      else if (32'(bins_r[a]) > MaxBins)     eb[a] = BinW'(MaxBins);
      else                                    eb[a] = BinW'(bins_r[a]);
    end
  end

  ugc_div #(.CoordBits(CoordBits), .BinW(BinW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .off   (off),
    .range (rng),
    .nbins (eb),
    .done  (div_done),
    .quo   (q)
  );

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (rng[a] == '0)         cl[a] = '0;
      else if (q[a] >= eb[a])   cl[a] = eb[a] - 1'b1;
      else                      cl[a] = q[a];
    end
  end

  assign sts = {bad_r, div_done};

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_pi  <= qi_r;
      out_bad <= bad_r;
      out_cx  <= bad_r ? '0 : CellW'(cl[0]);
      out_cy  <= bad_r ? '0 : CellW'(cl[1]);
      out_cz  <= bad_r ? '0 : CellW'(cl[2]);
    end
  end
endmodule

>>> sv/uniform_grid_cell_3d_unit.sv
// channel | dir | handshake            | words
// in      | in  | in_valid/in_ready    | opcode, x/y/z coord, query index
// out     | out | out_valid/out_ready  | point index, cell x/y/z, bad flag
// cfg     | in  | cfg_we               | bins register index + data
// Load, clear and ignored opcodes are taken in the accept cycle; in_ready stays high.
// A query drops in_ready through the store read, the BinW divider steps and the
// output load, BinW = $clog2(MaxBins + 1); a bad index skips the divider. The
// result word is valid the cycle after the output load.
// Synchronous active-low reset empties the set and sets all bins to 8.
// A result waits in the output register; the next query stalls only there.
module uniform_grid_cell_3d_unit
  import ugc_pkg::*;
#(
  parameter int MaxPoints = MaxPointsDef,
  parameter int CoordBits = CoordBitsDef,
  parameter int MaxBins   = MaxBinsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  logic [CoordBits-1:0]  in_x_coord,
  input  logic [CoordBits-1:0]  in_y_coord,
  input  logic [CoordBits-1:0]  in_z_coord,
  input  logic [IdxW-1:0]       in_query_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IdxW-1:0]       out_point_index,
  output logic [CellW-1:0]      out_cell_x,
  output logic [CellW-1:0]      out_cell_y,
  output logic [CellW-1:0]      out_cell_z,
  output logic                  out_bad_index,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CfgW-1:0]       cfg_data
);
  ctl_t ctl;
  sts_t sts;

  ugc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ugc_dp #(.MaxPoints(MaxPoints), .CoordBits(CoordBits), .MaxBins(MaxBins)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_x      (in_x_coord),
    .in_y      (in_y_coord),
    .in_z      (in_z_coord),
    .in_qi     (in_query_index),
    .out_pi    (out_point_index),
    .out_cx    (out_cell_x),
    .out_cy    (out_cell_y),
    .out_cz    (out_cell_z),
    .out_bad   (out_bad_index)
  );
endmodule

>>> sv/ugc_checker.sv
module ugc_checker
  import ugc_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [IdxW-1:0] out_point_index,
  input logic [CellW-1:0] out_cell_x,
  input logic            out_bad_index
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_index) &&
      $stable(out_cell_x) && $stable(out_bad_index))
    else $error("result dropped while stalled");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_cell_x == '0)
    else $error("bad index with nonzero cell");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  // a fresh result only comes out of a query, which holds the input off
  a_new_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word without a query");
endmodule

bind uniform_grid_cell_3d_unit ugc_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_point_index (out_point_index),
  .out_cell_x      (out_cell_x),
  .out_bad_index   (out_bad_index)
);

>>> tb/sv/uniform_grid_cell_3d_unit_test.sv
`timescale 1ns / 1ps

module uniform_grid_cell_3d_unit_test
  import ugc_pkg::*;
();

  localparam int NumPoints  = 1024;
  localparam int BinsCap    = 64;
  localparam int DrainWait  = 40;
  localparam int CycleLimit = 2000000;
  localparam int DueDepth   = 64;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [CellW-1:0] cx;
    logic [CellW-1:0] cy;
    logic [CellW-1:0] cz;
    logic             bad;
  } cell_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [9:0]  qi;
    logic        typed;
    cell_t       want;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_opcode;
  logic [15:0]           in_x_coord;
  logic [15:0]           in_y_coord;
  logic [15:0]           in_z_coord;
  logic [IdxW-1:0]       in_query_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [IdxW-1:0]       out_point_index;
  logic [CellW-1:0]      out_cell_x;
  logic [CellW-1:0]      out_cell_y;
  logic [CellW-1:0]      out_cell_z;
  logic                  out_bad_index;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CfgW-1:0]       cfg_data;

  uniform_grid_cell_3d_unit dut (.*);

  // grid model
  logic signed [15:0] pts [NumPoints][3];
  int                 npts;
  logic signed [15:0] lo [3];
  logic signed [15:0] hi [3];
  logic [CfgW-1:0]    bins_m [3];

  // expected words, in order
  cell_t due [DueDepth];
  int    due_wr;
  int    due_rd;
  int    errors;
  int    cycles;
  bit    no_idle;
  row_t  rows [19];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("uniform_grid_cell_3d_unit_test NOT OK");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [CellW-1:0] bin_of(input int a, input logic signed [15:0] v);
    longint nb, range, off, q;
    nb = (bins_m[a] == 0) ? 1 : (bins_m[a] > BinsCap) ? BinsCap : bins_m[a];
    range = longint'(hi[a]) - longint'(lo[a]);
    off = longint'(v) - longint'(lo[a]);
    if (range == 0) return '0;
    q = (off * nb) / range;
    if (q > nb - 1) q = nb - 1;
    return q[CellW-1:0];
  endfunction

  // advance the model by one accepted word; returns 1 when a cell label is due
  function automatic bit grid_step(input row_t r, output cell_t c);
    logic signed [15:0] v [3];
    c = '0;
    v[0] = r.x; v[1] = r.y; v[2] = r.z;
    case (r.op)
      OP_LOAD: begin
        if (npts < NumPoints) begin
          for (int a = 0; a < 3; a++) begin
            pts[npts][a] = v[a];
            if (npts == 0 || v[a] < lo[a]) lo[a] = v[a];
            if (npts == 0 || v[a] > hi[a]) hi[a] = v[a];
          end
          npts++;
        end
        return 1'b0;
      end
      OP_CLEAR: begin
        npts = 0;
        return 1'b0;
      end
      OP_QUERY: begin
        c.idx = r.qi;
        if (r.qi >= npts) begin
          c.bad = 1'b1;
        end else begin
          c.cx = bin_of(0, pts[r.qi][0]);
          c.cy = bin_of(1, pts[r.qi][1]);
          c.cz = bin_of(2, pts[r.qi][2]);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic row_t mk(input op_t op, input int x, input int y, input int z,
                              input int qi, input bit typed = 0, input cell_t want = '0);
    row_t r;
    r.op = op; r.x = x[15:0]; r.y = y[15:0]; r.z = z[15:0];
    r.qi = qi[9:0]; r.typed = typed; r.want = want;
    return r;
  endfunction

  task automatic send(input row_t r);
    int    gap;
    cell_t c;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= r.op;
    in_x_coord     <= r.x;
    in_y_coord     <= r.y;
    in_z_coord     <= r.z;
    in_query_index <= r.qi;
    do @(posedge clk); while (!in_ready);
    if (grid_step(r, c)) begin
      due[due_wr % DueDepth] = r.typed ? r.want : c;
      due_wr++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_wr != due_rd) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_bins(input int bx, input int by, input int bz);
    int v [3];
    v[0] = bx; v[1] = by; v[2] = bz;
    drain();
    for (int a = 0; a < 3; a++) begin
      cfg_we    <= 1'b1;
      cfg_index <= (a == 0) ? REG_BINS_X : (a == 1) ? REG_BINS_Y : REG_BINS_Z;
      cfg_data  <= v[a][CfgW-1:0];
      bins_m[a] = v[a][CfgW-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 200)) - 100;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // mostly loads, so that the store keeps growing over the run
  function automatic row_t rand_row();
    int r;
    r = $urandom_range(0, 99);
    if (r < 1) return mk(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom());
    if (r < 7) begin
      if (npts > 0 && $urandom_range(0, 4) != 0)
        return mk(OP_QUERY, $urandom(), $urandom(), $urandom(), $urandom_range(0, npts - 1));
      return mk(OP_QUERY, $urandom(), $urandom(), $urandom(), $urandom_range(0, 1023));
    end
    return mk(OP_LOAD, pick_coord(), pick_coord(), pick_coord(), $urandom());
  endfunction

  // result side
  initial begin
    int    gap;
    cell_t e;
    out_ready = 1'b0;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
      if (due_wr == due_rd) begin
        report("unexpected word, index", out_point_index, -1);
      end else begin
        e = due[due_rd % DueDepth];
        due_rd++;
        if (out_point_index !== e.idx) report("point_index", out_point_index, e.idx);
        if (out_cell_x !== e.cx) report("cell_x", out_cell_x, e.cx);
        if (out_cell_y !== e.cy) report("cell_y", out_cell_y, e.cy);
        if (out_cell_z !== e.cz) report("cell_z", out_cell_z, e.cz);
        if (out_bad_index !== e.bad) report("bad_index", out_bad_index, e.bad);
      end
    end
  end

  initial begin
    errors = 0; cycles = 0; no_idle = 0; npts = 0; due_wr = 0; due_rd = 0;
    for (int a = 0; a < 3; a++) begin
      lo[a] = '0; hi[a] = '0; bins_m[a] = 7'd8;
    end
    rst_n = 1'b0; in_valid = 1'b0; in_opcode = OP_NONE;
    in_x_coord = '0; in_y_coord = '0; in_z_coord = '0; in_query_index = '0;
    cfg_we = 1'b0; cfg_index = REG_BINS_X; cfg_data = '0;

    rows[0]  = mk(OP_QUERY, 0, 0, 0, 0, 1, '{10'd0, 6'd0, 6'd0, 6'd0, 1'b1});
    rows[1]  = mk(OP_QUERY, 0, 0, 0, 1023, 1, '{10'd1023, 6'd0, 6'd0, 6'd0, 1'b1});
    rows[2]  = mk(OP_LOAD, -32768, -32768, -32768, 0);
    rows[3]  = mk(OP_LOAD, 32767, 32767, 32767, 1023);
    rows[4]  = mk(OP_QUERY, 0, 0, 0, 0, 1, '{10'd0, 6'd0, 6'd0, 6'd0, 1'b0});
    // top of range clamps to bins-1
    rows[5]  = mk(OP_QUERY, 0, 0, 0, 1, 1, '{10'd1, 6'd7, 6'd7, 6'd7, 1'b0});
    rows[6]  = mk(OP_QUERY, 0, 0, 0, 2, 1, '{10'd2, 6'd0, 6'd0, 6'd0, 1'b1});
    rows[7]  = mk(OP_LOAD, 0, 0, 0, 0);
    rows[8]  = mk(OP_QUERY, 0, 0, 0, 2, 1, '{10'd2, 6'd4, 6'd4, 6'd4, 1'b0});
    rows[9]  = mk(OP_NONE, -1, -1, -1, 1023);
    rows[10] = mk(OP_QUERY, -1, -1, -1, 2);
    rows[11] = mk(OP_CLEAR, 0, 0, 0, 0);
    rows[12] = mk(OP_QUERY, 0, 0, 0, 0, 1, '{10'd0, 6'd0, 6'd0, 6'd0, 1'b1});
    rows[13] = mk(OP_LOAD, 5, -7, 100, 0);
    // single point: zero range on every axis
    rows[14] = mk(OP_QUERY, 0, 0, 0, 0, 1, '{10'd0, 6'd0, 6'd0, 6'd0, 1'b0});
    rows[15] = mk(OP_LOAD, 1000, -32768, 32767, 0);
    rows[16] = mk(OP_QUERY, 0, 0, 0, 1);
    rows[17] = mk(OP_QUERY, 0, 0, 0, 0);
    rows[18] = mk(OP_QUERY, 0, 0, 0, 3, 1, '{10'd3, 6'd0, 6'd0, 6'd0, 1'b1});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send(rows[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_bins(1, 64, 127);
        1: set_bins(0, 2, 63);
        2: set_bins(64, 127, 1);
        3: set_bins(127, 0, 64);
        default: set_bins($urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 127));
      endcase
      no_idle = (ph == 2);
      for (int n = 0; n < 120; n++) send(rand_row());
    end
    no_idle = 0;

    // fill the store to capacity; extra loads are dropped
    set_bins(64, 64, 64);
    while (npts < NumPoints)
      send(mk(OP_LOAD, pick_coord(), pick_coord(), pick_coord(), 0));
    for (int n = 0; n < 4; n++)
      send(mk(OP_LOAD, pick_coord(), pick_coord(), pick_coord(), 0));
    send(mk(OP_QUERY, 0, 0, 0, 1023));
    for (int n = 0; n < 8; n++)
      send(mk(OP_QUERY, 0, 0, 0, $urandom_range(0, 1023)));
    send(mk(OP_CLEAR, 0, 0, 0, 0));
    send(mk(OP_QUERY, 0, 0, 0, 0));

    drain();
    if (errors == 0) begin
      $display("uniform_grid_cell_3d_unit_test OK");
    end else begin
      $display("uniform_grid_cell_3d_unit_test NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ugc_pkg.sv
sv/ugc_ctrl.sv
sv/ugc_div.sv
sv/ugc_dp.sv
sv/uniform_grid_cell_3d_unit.sv
sv/ugc_checker.sv
tb/sv/uniform_grid_cell_3d_unit_test.sv
